// File: sv/mehp_pkg.sv
// Shared constants and types of the escape-time hue pixel block.
package mehp_pkg;

    // Coordinate format and iteration counter
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 28;
    localparam int COUNT_WIDTH = 10;

    // Full product width of one coordinate multiply
    localparam int PROD_WIDTH = 2 * COORD_WIDTH;

    // Color arithmetic: 6*n and 255*v widths, divider step counter
    localparam int SIX_WIDTH  = COUNT_WIDTH + 3;
    localparam int DIV_WIDTH  = COUNT_WIDTH + 8;
    localparam int DCNT_WIDTH = $clog2(DIV_WIDTH + 1);

    // Stream widths, rounded up to whole bytes
    localparam int IN_DATA_WIDTH  = ((2 * COORD_WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_WIDTH = ((COUNT_WIDTH + 24 + 7) / 8) * 8;

    localparam logic [COUNT_WIDTH-1:0] MAX_ITER_RESET = COUNT_WIDTH'(120);

    // Escape box (|part| > 4) and magnitude threshold (|z|^2 > 16)
    localparam logic signed [PROD_WIDTH-1:0] Z_LIMIT     = PROD_WIDTH'(4) << FRAC_BITS;
    localparam logic signed [PROD_WIDTH-1:0] Z_LIMIT_NEG = -Z_LIMIT;
    localparam logic signed [PROD_WIDTH-1:0] MAG_LIMIT   =
        PROD_WIDTH'(1) << (2 * FRAC_BITS + 4);

    localparam logic [7:0] CH_FULL = 8'hFF;

    // Divider request and response
    typedef struct packed {
        logic                   start;
        logic [DIV_WIDTH-1:0]   dividend;
        logic [COUNT_WIDTH-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                   done;
        logic [DIV_WIDTH-1:0]   quot;
        logic [COUNT_WIDTH-1:0] rem;
    } t_div_rsp;

endpackage

// File: sv/mehp_mul.sv
// Shared signed coordinate multiplier with a registered product.
module mehp_mul (
    input  logic                                     i_clk,
    input  logic                                     i_en,
    input  logic signed [mehp_pkg::COORD_WIDTH-1:0]  i_a,
    input  logic signed [mehp_pkg::COORD_WIDTH-1:0]  i_b,
    output logic signed [mehp_pkg::PROD_WIDTH-1:0]   o_p
);
    import mehp_pkg::*;

    logic signed [PROD_WIDTH-1:0] r_p;

    // full-precision product, held until the next enabled cycle
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= PROD_WIDTH'(i_a) * PROD_WIDTH'(i_b);
        end
    end

    assign o_p = r_p;

endmodule

// File: sv/mehp_div.sv
// Restoring divider, one quotient bit per cycle, for the hue arithmetic.
module mehp_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mehp_pkg::t_div_req i_req,
    output mehp_pkg::t_div_rsp o_rsp
);
    import mehp_pkg::*;

    logic                   r_busy;
    logic                   r_done;
    logic [DCNT_WIDTH-1:0]  r_cnt;
    logic [DIV_WIDTH-1:0]   r_quo;
    logic [COUNT_WIDTH-1:0] r_rem;
    logic [COUNT_WIDTH-1:0] r_dvs;

    logic [COUNT_WIDTH:0]   trial;
    logic [COUNT_WIDTH:0]   diff;
    logic                   fits;

    // one trial subtraction per step
    always_comb begin
        trial = {r_rem, r_quo[DIV_WIDTH-1]};
        diff  = trial - {1'b0, r_dvs};
        fits  = (trial >= {1'b0, r_dvs});
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_WIDTH'(DIV_WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_WIDTH'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // partial remainder and quotient shift
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= fits ? diff[COUNT_WIDTH-1:0] : trial[COUNT_WIDTH-1:0];
            r_quo <= {r_quo[DIV_WIDTH-2:0], fits};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

// File: sv/mandelbrot_escape_hue_pixel.sv
// Top level: escape-time test of one complex point with a hue color.
//
// One point c (Q4.28 real and imaginary parts) enters per input beat and one
// result beat leaves for it. The block works on one point at a time and takes
// no new point until the current one is done; a finished result waits in the
// output register, so the next point is taken while it is still unclaimed.
// Each iteration step runs through S_MXX, S_MYY, S_MXY and S_UPD: x*x, y*y and
// x*y go one after another through the single shared 32x32 multiplier, then
// S_UPD forms the new z and tests the escape box; the magnitude test of a step
// rides on the squares of the next one. With an iteration limit L, a point
// inside the set has its result ready once its step count reaches L. A point
// that escapes leaves by the box test or by the magnitude test, and then
// passes twice through the 18-step bit-serial divider that forms the hue
// sector and ramp. The sequencer returns to its idle state after each result
// before the next point is taken. The iteration limit resets to 120 and is
// written through the config channel, which is always ready; write it only
// while no point is in flight.
module mandelbrot_escape_hue_pixel (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // config: iteration limit
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [mehp_pkg::COUNT_WIDTH-1:0]       i_cfg_data,
    // input beat: c_re, c_im
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [mehp_pkg::IN_DATA_WIDTH-1:0]     s_axis_tdata,
    // output beat: escape_count, red, green, blue, zero pad
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [mehp_pkg::OUT_DATA_WIDTH-1:0]    m_axis_tdata,
    // tuser: in_set
    output logic [0:0]                             m_axis_tuser
);
    import mehp_pkg::*;

    // hue sectors of 60 degrees
    localparam logic [2:0] SEC_R_GUP = 3'd0;
    localparam logic [2:0] SEC_G_RDN = 3'd1;
    localparam logic [2:0] SEC_G_BUP = 3'd2;
    localparam logic [2:0] SEC_B_GDN = 3'd3;
    localparam logic [2:0] SEC_B_RUP = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MXX,
        S_MYY,
        S_MXY,
        S_UPD,
        S_D1GO,
        S_D1WAIT,
        S_RAMP,
        S_D2GO,
        S_D2WAIT,
        S_DONE
    } t_state;

    t_state                        r_state;
    logic [COUNT_WIDTH-1:0]        r_max;
    logic signed [COORD_WIDTH-1:0] r_cr;
    logic signed [COORD_WIDTH-1:0] r_ci;
    logic signed [COORD_WIDTH-1:0] r_x;
    logic signed [COORD_WIDTH-1:0] r_y;
    logic [COUNT_WIDTH-1:0]        r_n;
    logic                          r_chk;
    logic signed [PROD_WIDTH-1:0]  r_xx;
    logic signed [PROD_WIDTH-1:0]  r_dif;
    logic [2:0]                    r_sec;
    logic [COUNT_WIDTH-1:0]        r_rem;
    logic [DIV_WIDTH-1:0]          r_num;
    logic                          r_res_in;
    logic [7:0]                    r_res_red;
    logic [7:0]                    r_res_green;
    logic [7:0]                    r_res_blue;
    logic                          r_o_valid;
    logic [COUNT_WIDTH-1:0]        r_o_cnt;
    logic                          r_o_in;
    logic [7:0]                    r_o_red;
    logic [7:0]                    r_o_green;
    logic [7:0]                    r_o_blue;

    logic                          mul_en;
    logic signed [COORD_WIDTH-1:0] mul_a;
    logic signed [COORD_WIDTH-1:0] mul_b;
    logic signed [PROD_WIDTH-1:0]  prod;
    logic signed [PROD_WIDTH-1:0]  mag;
    logic signed [PROD_WIDTH-1:0]  dif;
    logic signed [PROD_WIDTH-1:0]  nx;
    logic signed [PROD_WIDTH-1:0]  ny;
    logic                          box_out;
    logic [SIX_WIDTH-1:0]          six;
    logic [COUNT_WIDTH-1:0]        ramp_base;
    logic [DIV_WIDTH-1:0]          num;
    logic [7:0]                    ramp;
    logic [7:0]                    col_red;
    logic [7:0]                    col_green;
    logic [7:0]                    col_blue;
    t_div_req                      div_req;
    t_div_rsp                      div_rsp;

    // operand select for the shared multiplier
    always_comb begin
        mul_en = 1'b1;
        mul_a  = r_x;
        mul_b  = r_x;
        unique case (r_state)
            S_MXX: begin
                mul_a = r_x;
                mul_b = r_x;
            end
            S_MYY: begin
                mul_a = r_y;
                mul_b = r_y;
            end
            S_MXY: begin
                mul_a = r_x;
                mul_b = r_y;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    mehp_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (prod)
    );

    // iteration datapath: |z|^2 of the previous step, new z, escape box
    always_comb begin
        mag     = r_xx + prod;
        dif     = r_xx - prod;
        nx      = (r_dif >>> FRAC_BITS) + PROD_WIDTH'(r_cr);
        ny      = (prod >>> (FRAC_BITS - 1)) + PROD_WIDTH'(r_ci);
        box_out = (nx > Z_LIMIT) || (nx < Z_LIMIT_NEG) ||
                  (ny > Z_LIMIT) || (ny < Z_LIMIT_NEG);
    end

    // hue arithmetic: 6n, then 255 * (ramp fraction numerator)
    always_comb begin
        six       = (SIX_WIDTH'(r_n) << 2) + (SIX_WIDTH'(r_n) << 1);
        // odd sector falls, even sector rises
        ramp_base = r_sec[0] ? (r_max - r_rem) : r_rem;
        num       = (DIV_WIDTH'(ramp_base) << 8) - DIV_WIDTH'(ramp_base);
    end

    // divider requests: first 6n / max, then 255*v / max
    always_comb begin
        div_req.start    = (r_state == S_D1GO) || (r_state == S_D2GO);
        div_req.dividend = (r_state == S_D1GO) ? DIV_WIDTH'(six) : r_num;
        div_req.divisor  = r_max;
    end

    mehp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // sector to RGB
    always_comb begin
        ramp      = div_rsp.quot[7:0];
        col_red   = '0;
        col_green = '0;
        col_blue  = '0;
        unique case (r_sec)
            SEC_R_GUP: begin
                col_red   = CH_FULL;
                col_green = ramp;
            end
            SEC_G_RDN: begin
                col_red   = ramp;
                col_green = CH_FULL;
            end
            SEC_G_BUP: begin
                col_green = CH_FULL;
                col_blue  = ramp;
            end
            SEC_B_GDN: begin
                col_green = ramp;
                col_blue  = CH_FULL;
            end
            SEC_B_RUP: begin
                col_red   = ramp;
                col_blue  = CH_FULL;
            end
            default: begin
                col_red   = CH_FULL;
                col_blue  = ramp;
            end
        endcase
    end

    // sequencer, config register and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_max     <= MAX_ITER_RESET;
            r_chk     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_max <= i_cfg_data;
            end
            // the done state reloads the output register itself
            if (r_o_valid && m_axis_tready && (r_state != S_DONE)) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cr    <= s_axis_tdata[COORD_WIDTH-1:0];
                        r_ci    <= s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
                        r_x     <= s_axis_tdata[COORD_WIDTH-1:0];
                        r_y     <= s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
                        r_n     <= '0;
                        r_chk   <= 1'b0;
                        r_state <= S_MXX;
                    end
                end
                S_MXX: begin
                    r_state <= S_MYY;
                end
                S_MYY: begin
                    r_xx    <= prod;
                    r_state <= S_MXY;
                end
                S_MXY: begin
                    r_dif <= dif;
                    // magnitude test of the previous step uses this step's squares
                    priority if (r_chk && (mag > MAG_LIMIT)) begin
                        r_n     <= r_n - 1'b1;
                        r_state <= S_D1GO;
                    end else if (r_n == r_max) begin
                        r_res_in    <= 1'b1;
                        r_res_red   <= '0;
                        r_res_green <= '0;
                        r_res_blue  <= '0;
                        r_state     <= S_DONE;
                    end else begin
                        r_state <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (box_out) begin
                        r_state <= S_D1GO;
                    end else begin
                        r_x     <= nx[COORD_WIDTH-1:0];
                        r_y     <= ny[COORD_WIDTH-1:0];
                        r_n     <= r_n + 1'b1;
                        r_chk   <= 1'b1;
                        r_state <= S_MXX;
                    end
                end
                S_D1GO: begin
                    r_state <= S_D1WAIT;
                end
                S_D1WAIT: begin
                    if (div_rsp.done) begin
                        r_sec   <= div_rsp.quot[2:0];
                        r_rem   <= div_rsp.rem;
                        r_state <= S_RAMP;
                    end
                end
                S_RAMP: begin
                    r_num   <= num;
                    r_state <= S_D2GO;
                end
                S_D2GO: begin
                    r_state <= S_D2WAIT;
                end
                S_D2WAIT: begin
                    if (div_rsp.done) begin
                        r_res_in    <= 1'b0;
                        r_res_red   <= col_red;
                        r_res_green <= col_green;
                        r_res_blue  <= col_blue;
                        r_state     <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_o_valid || m_axis_tready) begin
                        r_o_valid <= 1'b1;
                        r_o_cnt   <= r_n;
                        r_o_in    <= r_res_in;
                        r_o_red   <= r_res_red;
                        r_o_green <= r_res_green;
                        r_o_blue  <= r_res_blue;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // ports
    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = OUT_DATA_WIDTH'({r_o_blue, r_o_green, r_o_red, r_o_cnt});
    assign m_axis_tuser  = r_o_in;

    // z carried into a checked step lies inside the escape box
    a_z_in_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_chk && (r_state == S_MXX)) |->
        ((PROD_WIDTH'(r_x) <= Z_LIMIT) && (PROD_WIDTH'(r_x) >= Z_LIMIT_NEG) &&
         (PROD_WIDTH'(r_y) <= Z_LIMIT) && (PROD_WIDTH'(r_y) >= Z_LIMIT_NEG)))
        else $error("iterate left the escape box unflagged");

    // divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> ((r_state == S_D1WAIT) || (r_state == S_D2WAIT)))
        else $error("divider result arrived outside a wait state");

    // a point in the set is black
    a_in_set_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |->
        ((r_o_red == '0) && (r_o_green == '0) && (r_o_blue == '0)))
        else $error("in-set result carries a color");

    // an accepted point starts at step zero with no pending magnitude test
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=>
        ((r_state == S_MXX) && (r_n == '0) && !r_chk))
        else $error("iteration did not start cleanly");

endmodule
